@@ src/cmfuv_pkg.sv @@
// cmfuv_pkg: shared widths and face codes for the cube map face and uv lookup
// no dependencies; imported by cube_map_face_uv_lookup_core, cmfuv_checker and tb_top
`timescale 1ns / 1ps
`default_nettype none

package cmfuv_pkg;

  // fixed field widths
  localparam int DIR_W  = 16;  // signed direction components
  localparam int UV_W   = 16;  // texture coordinate ports
  localparam int FACE_W = 3;   // face code

  typedef enum logic [FACE_W-1:0] {
    FACE_FRONT  = 3'd0,  // +z
    FACE_BACK   = 3'd1,  // -z
    FACE_LEFT   = 3'd2,  // +x
    FACE_RIGHT  = 3'd3,  // -x
    FACE_BOTTOM = 3'd4,  // +y
    FACE_TOP    = 3'd5   // -y, also the zero vector
  } face_e;

endpackage

`default_nettype wire

@@ src/cube_map_face_uv_lookup_core.sv @@
// cube_map_face_uv_lookup_core: projects a direction onto the unit cube, picks the face
// and produces rounded face texture coordinates; depends on cmfuv_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o   | dir_x_i, dir_y_i, dir_z_i
//  out     | out_valid_o / out_stall_i | face_o, face_u_o, face_v_o, degenerate_o
//
//  one item per clock sustained while out_stall_i is low
//  most register stages form the restoring divider, one quotient bit per register stage
//  reset clears the valid bit of every stage; payload registers are not reset
//  each stage holds only when it and every later stage are full and out_stall_i is
//  high, so bubbles close up and an item is taken while a result waits at the output

module cube_map_face_uv_lookup_core
  import cmfuv_pkg::*;
#(
  parameter int UV_FRAC_BITS = 15
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // input item channel
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire  signed [DIR_W-1:0] dir_x_i,
  input  wire  signed [DIR_W-1:0] dir_y_i,
  input  wire  signed [DIR_W-1:0] dir_z_i,
  // result item channel
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [FACE_W-1:0]       face_o,
  output logic [UV_W-1:0]         face_u_o,
  output logic [UV_W-1:0]         face_v_o,
  output logic                    degenerate_o
);

  // quotient bits, one divider stage each; the quotient reaches 2^UV_FRAC_BITS
  localparam int QW     = UV_FRAC_BITS + 1;
  // 2*m with m up to 32768
  localparam int DEN_W  = DIR_W + 1;
  // n * 2^UV_FRAC_BITS + m with n up to 2*m
  localparam int NUM_W  = DEN_W + UV_FRAC_BITS;
  // partial remainder stays below 2*m
  localparam int REM_W  = DIR_W;
  // stage 1 abs/max, stage 2 face select, then QW+1 divider registers
  localparam int NST    = QW + 3;
  localparam logic [QW-1:0] HALF_Q = QW'(1) << (UV_FRAC_BITS - 1);
  localparam logic [QW-1:0] MAX_Q  = QW'(1) << UV_FRAC_BITS;

  typedef struct packed {
    face_e              face;
    logic               degen;
    logic [DEN_W-1:0]   den;
    logic [REM_W-1:0]   rem_u;
    logic [REM_W-1:0]   rem_v;
    logic [QW-1:0]      lq_u;   // dividend bits still to use, quotient bits shift in
    logic [QW-1:0]      lq_v;
  } dv_t;

  // ---------------------------------------------------------------------------
  // flow control: valid bits per stage, stage k loads unless it and everything
  // after it are full while the output is stalled
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      adv[k] = !out_stall_i || !(&(v_q | ((NST'(1) << k) - NST'(1))));
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: absolute values and largest magnitude m
  // ---------------------------------------------------------------------------
  logic [DIR_W-1:0] abs_x, abs_y, abs_z, max_xy, m_d;
  logic [DIR_W-1:0] s1_x_q, s1_y_q, s1_z_q, s1_m_q;

  always_comb begin
    abs_x  = dir_x_i[DIR_W-1] ? (~dir_x_i + 1'b1) : dir_x_i;
    abs_y  = dir_y_i[DIR_W-1] ? (~dir_y_i + 1'b1) : dir_y_i;
    abs_z  = dir_z_i[DIR_W-1] ? (~dir_z_i + 1'b1) : dir_z_i;
    max_xy = (abs_y > abs_x) ? abs_y : abs_x;
    m_d    = (abs_z > max_xy) ? abs_z : max_xy;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_x_q <= dir_x_i;
      s1_y_q <= dir_y_i;
      s1_z_q <= dir_z_i;
      s1_m_q <= m_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: face by priority (z, then x, then y), pick the two components with
  // their sign flips and shift them from [-m, m] to [0, 2m]
  // ---------------------------------------------------------------------------
  logic [DEN_W-1:0] xs, ys, zs, ms, neg_m, a_sel, b_sel, n_u_d, n_v_d;
  face_e            face_d;
  logic             degen_d;

  logic [DEN_W-1:0] s2_n_u_q, s2_n_v_q;
  logic [DIR_W-1:0] s2_m_q;
  face_e            s2_face_q;
  logic             s2_degen_q;

  always_comb begin
    xs      = {s1_x_q[DIR_W-1], s1_x_q};
    ys      = {s1_y_q[DIR_W-1], s1_y_q};
    zs      = {s1_z_q[DIR_W-1], s1_z_q};
    ms      = {1'b0, s1_m_q};
    neg_m   = ~ms + 1'b1;
    degen_d = (s1_m_q == '0);
    if (degen_d) begin
      face_d = FACE_TOP;
      a_sel  = '0;
      b_sel  = '0;
    end else if (zs == ms) begin
      face_d = FACE_FRONT;
      a_sel  = ~xs + 1'b1;
      b_sel  = ys;
    end else if (zs == neg_m) begin
      face_d = FACE_BACK;
      a_sel  = xs;
      b_sel  = ys;
    end else if (xs == ms) begin
      face_d = FACE_LEFT;
      a_sel  = zs;
      b_sel  = ys;
    end else if (xs == neg_m) begin
      face_d = FACE_RIGHT;
      a_sel  = ~zs + 1'b1;
      b_sel  = ys;
    end else if (ys == ms) begin
      face_d = FACE_BOTTOM;
      a_sel  = ~xs + 1'b1;
      b_sel  = ~zs + 1'b1;
    end else begin
      face_d = FACE_TOP;
      a_sel  = ~xs + 1'b1;
      b_sel  = zs;
    end
    // true sum lies in [0, 2m], so the wrapped 17-bit sum is exact
    n_u_d = a_sel + ms;
    n_v_d = b_sel + ms;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_n_u_q   <= n_u_d;
      s2_n_v_q   <= n_v_d;
      s2_m_q     <= s1_m_q;
      s2_face_q  <= face_d;
      s2_degen_q <= degen_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: dividend n * 2^UV_FRAC_BITS + m (the +m rounds to nearest),
  // divisor 2m; the upper bits already sit below the divisor
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] num_u, num_v;
  dv_t              dv_0_d;
  dv_t              dv_q [0:QW];
  dv_t              dv_d [1:QW];

  always_comb begin
    num_u              = {s2_n_u_q, {UV_FRAC_BITS{1'b0}}} + NUM_W'(s2_m_q);
    num_v              = {s2_n_v_q, {UV_FRAC_BITS{1'b0}}} + NUM_W'(s2_m_q);
    dv_0_d.face        = s2_face_q;
    dv_0_d.degen       = s2_degen_q;
    dv_0_d.den         = {s2_m_q, 1'b0};
    dv_0_d.rem_u       = num_u[NUM_W-1:QW];
    dv_0_d.rem_v       = num_v[NUM_W-1:QW];
    dv_0_d.lq_u        = num_u[QW-1:0];
    dv_0_d.lq_v        = num_v[QW-1:0];
  end

  // ---------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage for both coordinates
  // ---------------------------------------------------------------------------
  logic [DEN_W-1:0] t_u [1:QW];
  logic [DEN_W-1:0] t_v [1:QW];
  logic             qb_u [1:QW];
  logic             qb_v [1:QW];

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      t_u[k]  = {dv_q[k-1].rem_u, dv_q[k-1].lq_u[QW-1]};
      t_v[k]  = {dv_q[k-1].rem_v, dv_q[k-1].lq_v[QW-1]};
      qb_u[k] = (t_u[k] >= dv_q[k-1].den);
      qb_v[k] = (t_v[k] >= dv_q[k-1].den);
      dv_d[k] = dv_q[k-1];
      dv_d[k].rem_u = qb_u[k] ? REM_W'(t_u[k] - dv_q[k-1].den) : REM_W'(t_u[k]);
      dv_d[k].rem_v = qb_v[k] ? REM_W'(t_v[k] - dv_q[k-1].den) : REM_W'(t_v[k]);
      dv_d[k].lq_u  = {dv_q[k-1].lq_u[QW-2:0], qb_u[k]};
      dv_d[k].lq_v  = {dv_q[k-1].lq_v[QW-2:0], qb_v[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      dv_q[0] <= dv_0_d;
    end
    for (int k = 1; k <= QW; k++) begin
      if (adv[k+2]) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output: last divider register; zero vector reads as one half on both axes
  // ---------------------------------------------------------------------------
  logic [QW-1:0]      q_u, q_v;
  logic [QW+UV_W-1:0] wide_u, wide_v;

  always_comb begin
    q_u    = dv_q[QW].degen ? HALF_Q : dv_q[QW].lq_u;
    q_v    = dv_q[QW].degen ? HALF_Q : dv_q[QW].lq_v;
    wide_u = {{UV_W{1'b0}}, q_u};
    wide_v = {{UV_W{1'b0}}, q_v};
  end

  assign out_valid_o  = v_q[NST-1];
  assign face_o       = dv_q[QW].face;
  assign face_u_o     = wide_u[UV_W-1:0];
  assign face_v_o     = wide_v[UV_W-1:0];
  assign degenerate_o = dv_q[QW].degen;

`ifndef NO_ASSERTIONS
  // zero vector must always land on the top face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> face_o == FACE_TOP)
    else $error("degenerate item not on top face");

  // a rounded coordinate never exceeds 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> dv_q[QW].lq_u <= MAX_Q && dv_q[QW].lq_v <= MAX_Q)
    else $error("face coordinate above one");

  // divider remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
      DEN_W'(dv_q[QW].rem_u) < dv_q[QW].den && DEN_W'(dv_q[QW].rem_v) < dv_q[QW].den)
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

@@ tb/cmfuv_checker.sv @@
// cmfuv_checker: watches both channels of cube_map_face_uv_lookup_core, predicts face and uv
// for every accepted direction and compares results in order; depends on cmfuv_pkg
`timescale 1ns / 1ps

module cmfuv_checker
  import cmfuv_pkg::*;
#(
  parameter int UV_FRAC_BITS = 15
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  input  wire                     in_stall_i,
  input  wire  signed [DIR_W-1:0] dir_x_i,
  input  wire  signed [DIR_W-1:0] dir_y_i,
  input  wire  signed [DIR_W-1:0] dir_z_i,
  input  wire                     out_valid_i,
  input  wire                     out_stall_i,
  input  wire  [FACE_W-1:0]       face_i,
  input  wire  [UV_W-1:0]         face_u_i,
  input  wire  [UV_W-1:0]         face_v_i,
  input  wire                     degenerate_i,
  output int                      err_count_o,
  output int                      pending_o
);

  typedef struct packed {
    face_e           face;
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
    logic            degenerate;
  } lookup_t;

  lookup_t lookup_q[$];
  int      n_results = 0;
  int      n_errors  = 0;

  assign err_count_o = n_errors;
  assign pending_o   = lookup_q.size();

  // (c + m) / 2m in Q1.UV_FRAC_BITS, halves rounded up
  function automatic logic [UV_W-1:0] to_coord(longint c, longint m);
    longint num;
    num = ((c + m) <<< UV_FRAC_BITS) + m;
    return UV_W'(num / (2 * m));
  endfunction

  function automatic lookup_t cube_lookup(logic signed [DIR_W-1:0] x_in,
                                          logic signed [DIR_W-1:0] y_in,
                                          logic signed [DIR_W-1:0] z_in);
    longint  x, y, z, m, a, b;
    lookup_t r;
    x = x_in;
    y = y_in;
    z = z_in;
    m = (x < 0) ? -x : x;
    if (((y < 0) ? -y : y) > m) m = (y < 0) ? -y : y;
    if (((z < 0) ? -z : z) > m) m = (z < 0) ? -z : z;
    if (m == 0) begin
      r.face       = FACE_TOP;
      r.u          = UV_W'(longint'(1) <<< (UV_FRAC_BITS - 1));
      r.v          = r.u;
      r.degenerate = 1'b1;
      return r;
    end
    // z first, then x, then y decides ties
    if (z == m) begin
      r.face = FACE_FRONT;  a = -x; b = y;
    end else if (z == -m) begin
      r.face = FACE_BACK;   a = x;  b = y;
    end else if (x == m) begin
      r.face = FACE_LEFT;   a = z;  b = y;
    end else if (x == -m) begin
      r.face = FACE_RIGHT;  a = -z; b = y;
    end else if (y == m) begin
      r.face = FACE_BOTTOM; a = -x; b = -z;
    end else begin
      r.face = FACE_TOP;    a = -x; b = z;
    end
    r.u          = to_coord(a, m);
    r.v          = to_coord(b, m);
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        lookup_q.push_back(cube_lookup(dir_x_i, dir_y_i, dir_z_i));
      if (out_valid_i && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected item, face", face_i, -1);
        end else begin
          want = lookup_q.pop_front();
          if (face_i !== want.face)             report_mismatch("face", face_i, want.face);
          if (face_u_i !== want.u)              report_mismatch("face_u", face_u_i, want.u);
          if (face_v_i !== want.v)              report_mismatch("face_v", face_v_i, want.v);
          if (degenerate_i !== want.degenerate)
            report_mismatch("degenerate", degenerate_i, want.degenerate);
        end
        n_results++;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus and verdict for cube_map_face_uv_lookup_core; directed corner
// directions, then random ones under three idling mixes; checking lives in cmfuv_checker
`timescale 1ns / 1ps

module tb_top
  import cmfuv_pkg::*;
();

  localparam int UV_FRAC_BITS = 15;
  localparam int N_PER_PHASE  = 442;   // three random phases after the directed list
  localparam int HOLD_CYCLES  = 80;    // long enough to fill the whole pipeline
  localparam int DRAIN_LIMIT  = 5000;  // cycles allowed for the last results
  localparam int TAIL_CYCLES  = 40;    // wait past the pipeline depth for stray results

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    out_stall_i = 1'b0;
  logic signed [DIR_W-1:0] dir_x_i     = '0;
  logic signed [DIR_W-1:0] dir_y_i     = '0;
  logic signed [DIR_W-1:0] dir_z_i     = '0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [FACE_W-1:0]       face_o;
  logic [UV_W-1:0]         face_u_o;
  logic [UV_W-1:0]         face_v_o;
  logic                    degenerate_o;

  int err_count;
  int pending;

  // idle percentages of sender and receiver, changed between phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // asks the receiver for one long hold-off; the receiver counts it out itself
  bit hold_req    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cube_map_face_uv_lookup_core #(
    .UV_FRAC_BITS(UV_FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .face_o      (face_o),
    .face_u_o    (face_u_o),
    .face_v_o    (face_v_o),
    .degenerate_o(degenerate_o)
  );

  cmfuv_checker #(
    .UV_FRAC_BITS(UV_FRAC_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .face_i      (face_o),
    .face_u_i    (face_u_o),
    .face_v_i    (face_v_o),
    .degenerate_i(degenerate_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // receiver: random stalls, plus one long hold-off so the block backs up
  // into its input and has to raise in_stall_o
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // offer one direction item; called at a rising edge, returns at the edge of acceptance
  // valid is only ever written once per edge, so back-to-back items keep it high
  task automatic send_dir(input int x, input int y, input int z);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dir_x_i    <= DIR_W'(x);
    dir_y_i    <= DIR_W'(y);
    dir_z_i    <= DIR_W'(z);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // random direction; mostly in-range vectors, with full-width noise, forced ties
  // between largest components, tiny vectors for rounding and one dominant axis
  task automatic send_random_dir();
    int kind, m, axis, sel;
    int c[3];
    kind = $urandom_range(99);
    if (kind < 45) begin
      foreach (c[i]) c[i] = int'($urandom_range(32768)) - 16384;
    end else if (kind < 60) begin
      // full 16 bit patterns, out-of-range values such as -32768 included
      foreach (c[i]) c[i] = int'($urandom_range(65535)) - 32768;
    end else if (kind < 75) begin
      // every axis is +m, -m or smaller, so ties come up often
      m = $urandom_range(1, 32767);
      foreach (c[i]) begin
        sel = $urandom_range(2);
        if (sel == 0)      c[i] = m;
        else if (sel == 1) c[i] = -m;
        else               c[i] = int'($urandom_range(2 * m)) - m;
      end
    end else if (kind < 87) begin
      // very short vectors, where the rounding of the quotient matters most
      foreach (c[i]) c[i] = int'($urandom_range(6)) - 3;
    end else begin
      axis = $urandom_range(2);
      m    = $urandom_range(8192, 16384);
      foreach (c[i]) c[i] = int'($urandom_range(2 * m)) - m;
      c[axis] = $urandom_range(1) ? m : -m;
    end
    send_dir(c[0], c[1], c[2]);
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vector, each axis both ways, ties on every priority step,
    // out-of-range extremes and short vectors that round at the half
    send_dir(0, 0, 0);
    send_dir(0, 0, 16384);
    send_dir(0, 0, -16384);
    send_dir(16384, 0, 0);
    send_dir(-16384, 0, 0);
    send_dir(0, 16384, 0);
    send_dir(0, -16384, 0);
    send_dir(16384, 16384, 16384);      // three-way tie, z wins
    send_dir(-16384, -16384, -16384);
    send_dir(16384, -16384, 0);         // x against y, x wins
    send_dir(-16384, 16384, 0);
    send_dir(0, 16384, -16383);
    send_dir(-32768, -32768, -32768);   // magnitude 32768
    send_dir(32767, -32768, 100);
    send_dir(-32768, 32767, 32767);
    send_dir(1, 0, 0);
    send_dir(0, 0, -1);
    send_dir(1, 1, -1);
    send_dir(3, 1, 2);
    send_dir(11585, 11585, 0);
    send_dir(-1, -1, 0);
    send_dir(0, -1, 0);
    send_dir(5, -7, 3);
    send_dir(0, 32767, -32767);

    // sender mostly busy, receiver often stalled
    tx_idle_pct = 10;
    rx_idle_pct = 52;
    repeat (N_PER_PHASE) send_random_dir();

    // sender often idle, receiver mostly ready
    tx_idle_pct = 52;
    rx_idle_pct = 10;
    repeat (N_PER_PHASE) send_random_dir();

    // full rate both ways, with the long receiver hold-off at the start
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (N_PER_PHASE) send_random_dir();
    in_valid_i <= 1'b0;

    // drain what is still in flight, then give stray results time to show up
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // far beyond the length of a normal run
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
src/cmfuv_pkg.sv
src/cube_map_face_uv_lookup_core.sv
tb/cmfuv_checker.sv
tb/tb_top.sv
